[rtl/lsdt_pkg.sv]
// shared types and constants for the lru stack depth tracker
package lsdt_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int PAGE_W           = 32;
  localparam int DEPTH_W          = 4;
  localparam int CFG_W            = 5;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } page_item_t;

endpackage

[rtl/lsdt_front.sv]
// request intake and short queue feeding the stack engine
module lsdt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lsdt_pkg::PAGE_W-1:0]  page_number,
  output logic                         busy,
  output lsdt_pkg::page_item_t         item,
  input  logic                         pop
);

  localparam int QD   = lsdt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  logic [lsdt_pkg::PAGE_W-1:0] q_mem [QD];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        push;
  logic                        do_pop;

  assign busy   = (count == CNT_W'(QD));
  assign push   = start && !busy;
  assign do_pop = pop && (count != '0);

  assign item.valid = (count != '0);
  assign item.page  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QD - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QD - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/lsdt_back.sv]
// shifting lru stack with parallel compare, one request per cycle
module lsdt_back #(
  parameter int CAPACITY = lsdt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lsdt_pkg::page_item_t         item,
  output logic                         pop,
  input  logic                         cfg_wr_en,
  input  logic [lsdt_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic                         done,
  output logic                         hit,
  output logic [lsdt_pkg::DEPTH_W-1:0] depth
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LIM_W = (OCC_W > lsdt_pkg::CFG_W) ? OCC_W : lsdt_pkg::CFG_W;
  localparam int DW    = (IDX_W > lsdt_pkg::DEPTH_W) ? IDX_W : lsdt_pkg::DEPTH_W;

  logic [lsdt_pkg::PAGE_W-1:0]  stack [CAPACITY];
  logic [OCC_W-1:0]             occupancy;
  logic [lsdt_pkg::CFG_W-1:0]   max_entries;

  logic [CAPACITY-1:0]          match;
  logic                         found;
  logic [IDX_W-1:0]             pos;
  logic [LIM_W-1:0]             lim;
  logic [LIM_W-1:0]             cfg_ext;
  logic                         lim_nz;
  logic [LIM_W:0]               occ_inc;
  logic [OCC_W-1:0]             occupancy_next;
  logic [CAPACITY-1:0]          shift_en;
  logic [DW-1:0]                pos_ext;
  logic [lsdt_pkg::DEPTH_W-1:0] depth_next;

  assign pop = item.valid;

  // limit in force
  assign cfg_ext = LIM_W'(max_entries);
  assign lim     = (cfg_ext > LIM_W'(CAPACITY)) ? LIM_W'(CAPACITY) : cfg_ext;
  assign lim_nz  = (lim != '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (stack[i] == item.page) && (OCC_W'(i) < occupancy);
    end
  end

  assign found = |match;

  // first match from the mru end
  always_comb begin
    pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IDX_W'(i);
      end
    end
  end

  assign occ_inc        = {1'b0, LIM_W'(occupancy)} + (LIM_W + 1)'(1);
  assign occupancy_next = (occ_inc > {1'b0, lim}) ? OCC_W'(lim) : OCC_W'(occ_inc);

  always_comb begin
    shift_en[0] = found || lim_nz;
    for (int i = 1; i < CAPACITY; i++) begin
      shift_en[i] = found ? (IDX_W'(i) <= pos) : lim_nz;
    end
  end

  assign pos_ext    = DW'(pos);
  assign depth_next = !found ? '0 :
                      (pos_ext > DW'({lsdt_pkg::DEPTH_W{1'b1}})) ?
                      {lsdt_pkg::DEPTH_W{1'b1}} : pos_ext[lsdt_pkg::DEPTH_W-1:0];

  always_ff @(posedge clk) begin
    if (item.valid) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (shift_en[i]) begin
          stack[i] <= (i == 0) ? item.page : stack[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hit   <= found;
    depth <= depth_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      occupancy   <= '0;
      max_entries <= lsdt_pkg::MAX_ENTRIES_RESET;
    end else begin
      done <= item.valid;
      if (item.valid && !found) begin
        occupancy <= occupancy_next;
      end
      if (cfg_wr_en) begin
        max_entries <= cfg_wr_data;
      end
    end
  end

endmodule

[rtl/lru_stack_depth_tracker_unit.sv]
// lru stack depth tracker top level
// a request is written into the queue, then compared and shifted; done, hit and depth are registered
// throughput: one request per cycle, set by the parallel compare and shift
// of the stack; busy rises only if the two-entry queue fills
// reset: synchronous, clears queue, occupancy and strobe; limit returns to 16
// results cannot be stalled by the receiver
module lru_stack_depth_tracker_unit #(
  parameter int CAPACITY = lsdt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lsdt_pkg::PAGE_W-1:0]  page_number,
  input  logic                         cfg_wr_en,
  input  logic [lsdt_pkg::CFG_W-1:0]   cfg_wr_data,
  output logic                         done,
  output logic                         hit,
  output logic [lsdt_pkg::DEPTH_W-1:0] depth
);

  lsdt_pkg::page_item_t item;
  logic                 pop;

  lsdt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .page_number (page_number),
    .busy        (busy),
    .item        (item),
    .pop         (pop)
  );

  lsdt_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .hit         (hit),
    .depth       (depth)
  );

endmodule

[rtl/lsdt_checker.sv]
// port-level checks for the lru stack depth tracker
module lsdt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         hit,
  input logic [lsdt_pkg::DEPTH_W-1:0] depth
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a request");

  a_fault_depth: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (depth == '0))
    else $error("fault with nonzero depth");

endmodule

bind lru_stack_depth_tracker_unit lsdt_checker u_lsdt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .hit   (hit),
  .depth (depth)
);
